/* rtl/core/fvc_pkg.sv */
`default_nettype none
package fvc_pkg;

   localparam int MaxSources = 64;
   localparam int CountW     = $clog2(MaxSources + 1);
   localparam int SumW       = 56;
   localparam int WtW        = 24;
   localparam int RemW       = 25;
   localparam int StepW      = $clog2(SumW);
   localparam int AddrW      = 3;

   localparam logic [2:0] ModeLinear   = 3'd0;
   localparam logic [2:0] ModeWeights  = 3'd1;
   localparam logic [2:0] ModePriority = 3'd2;
   localparam logic [2:0] ModeSelect   = 3'd5;

   localparam logic RegMode     = 1'b0;
   localparam logic RegSelected = 1'b1;

   typedef struct packed {
      logic [5:0]         source_index;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [15:0] source_weight;
      logic signed [15:0] source_priority;
      logic               last_source;
   } fvc_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               force_found;
   } fvc_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC,
      S_DSTART,
      S_DIV,
      S_STORE,
      S_DONE
   } fvc_state_type;

   typedef struct packed {
      logic load_item;
      logic accumulate;
      logic div_load;
      logic div_step;
      logic div_store;
      logic finish;
   } fvc_cmd_type;

   typedef struct packed {
      logic item_last;
      logic need_div;
      logic step_last;
      logic comp_last;
      logic out_free;
   } fvc_sts_type;

endpackage
`default_nettype wire

/* rtl/core/force_vector_combiner_top.sv */
// Force vector combiner.
// The req channel takes one word per force source of a particle, in source order;
// the word with last_source set closes the particle and yields one rsp word with
// the combined force. Configuration (combine mode, selected source) is written over
// the APB-style port at byte addresses 0 and 4; the user must write it only while
// the block is idle; the block itself does not enforce this. Each source word is
// registered and then accumulated. After the closing word, linear and weights
// modes with at least one nonzero source run a shared restoring divider, one
// quotient bit per cycle, over the three components in turn. Priority, select
// and the other modes give the result word without the divider.
// req_stall is high whenever the block is busy with a word or a particle close.
// The result sits in an output register; a stalled rsp word holds while the next
// particle's sources are accepted, and the next close waits until it is taken.
// Synchronous reset clears the registers to mode linear, source 0, and empties
// all per-particle sums and candidates and rsp_valid, but not the output data.
`default_nettype none
module force_vector_combiner_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire fvc_pkg::fvc_req_type     req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output fvc_pkg::fvc_rsp_type          rsp_payload,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [fvc_pkg::AddrW-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import fvc_pkg::*;

   fvc_cmd_type cmd;
   fvc_sts_type sts;

   fvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fvc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .cmd         (cmd),
      .sts         (sts)
   );

   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.last_source) |=> req_stall)
      else $error("closing word did not stall the input");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while input was open");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.force_found) |->
      (rsp_payload.out_x == 32'sd0 && rsp_payload.out_y == 32'sd0 &&
       rsp_payload.out_z == 32'sd0))
      else $error("missing force with nonzero vector");

endmodule
`default_nettype wire

/* rtl/core/fvc_ctrl.sv */
`default_nettype none
module fvc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire fvc_pkg::fvc_sts_type sts,
   output fvc_pkg::fvc_cmd_type     cmd
);
   import fvc_pkg::*;

   fvc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_ACC;
            end
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = sts.item_last ? S_DSTART : S_IDLE;
         end
         S_DSTART: begin
            if (sts.need_div) begin
               cmd.div_load = 1'b1;
               state_in     = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.step_last) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.div_store = 1'b1;
            state_in      = sts.comp_last ? S_DONE : S_DSTART;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/fvc_datapath.sv */
`default_nettype none
module fvc_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fvc_pkg::fvc_req_type     req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output fvc_pkg::fvc_rsp_type          rsp_payload,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [fvc_pkg::AddrW-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   input  wire fvc_pkg::fvc_cmd_type     cmd,
   output fvc_pkg::fvc_sts_type          sts
);
   import fvc_pkg::*;

   fvc_req_type             item_ff;
   logic [2:0]              mode_ff, mode_in;
   logic [5:0]              sel_ff, sel_in;
   logic [CountW-1:0]       cnt_ff, cnt_in;
   logic signed [SumW-1:0]  sum_ff [3];
   logic signed [SumW-1:0]  sum_in [3];
   logic signed [WtW-1:0]   wt_ff, wt_in;
   logic [CountW-1:0]       nz_ff, nz_in;
   logic signed [15:0]      bpri_ff, bpri_in;
   logic                    bfound_ff, bfound_in;
   logic signed [31:0]      bvec_ff [3];
   logic signed [31:0]      bvec_in [3];
   logic signed [31:0]      cvec_ff [3];
   logic signed [31:0]      cvec_in [3];
   logic                    cfound_ff, cfound_in;
   logic [1:0]              comp_ff, comp_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic [SumW-1:0]         dvd_ff, dvd_in;
   logic [RemW-1:0]         rem_ff, rem_in;
   logic [WtW-1:0]          div_ff, div_in;
   logic                    neg_ff, neg_in;
   logic signed [31:0]      q_ff [3];
   logic signed [31:0]      q_in [3];
   fvc_rsp_type             out_ff, out_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic signed [31:0]      f [3];
   logic signed [47:0]      prod [3];
   logic                    nonzero;
   logic                    cfg_wr;
   logic [RemW:0]           trial;
   logic [SumW-1:0]         mag;
   logic signed [SumW-1:0]  cur_sum;
   logic [WtW-1:0]          divisor;
   logic signed [31:0]      sat_q;
   fvc_rsp_type             result;

   assign f[0]    = item_ff.force_x;
   assign f[1]    = item_ff.force_y;
   assign f[2]    = item_ff.force_z;
   assign nonzero = (f[0] != 32'sd0) || (f[1] != 32'sd0) || (f[2] != 32'sd0);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i] = f[i] * 48'(item_ff.source_weight);
      end
   end

   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == RegSelected) ? {26'd0, sel_ff} : {29'd0, mode_ff};

   always_comb begin
      mode_in = mode_ff;
      sel_in  = sel_ff;
      if (cfg_wr) begin
         if (paddr[2] == RegMode) begin
            mode_in = pwdata[2:0];
         end else begin
            sel_in = pwdata[5:0];
         end
      end
   end

   // divisor: count in linear mode, weight total or 1.0 in weights mode
   always_comb begin
      if (mode_ff == ModeLinear) begin
         divisor = WtW'(nz_ff);
      end else if (wt_ff > 0) begin
         divisor = wt_ff;
      end else begin
         divisor = WtW'(256);
      end
   end

   assign cur_sum = sum_ff[comp_ff];
   assign mag     = cur_sum[SumW-1] ? SumW'(-cur_sum) : SumW'(cur_sum);
   assign trial   = {1'b0, rem_ff[RemW-2:0], dvd_ff[SumW-1]} - {2'b00, div_ff};

   // saturate quotient magnitude with sign
   always_comb begin
      if (!neg_ff) begin
         sat_q = (dvd_ff[SumW-1:31] != '0) ? 32'sh7FFFFFFF : $signed(dvd_ff[31:0]);
      end else if ((dvd_ff[SumW-1:32] != '0) || (dvd_ff[31] && (dvd_ff[30:0] != '0))) begin
         sat_q = 32'sh80000000;
      end else begin
         sat_q = -$signed(dvd_ff[31:0]);
      end
   end

   always_comb begin
      result = '0;
      case (mode_ff)
         ModeLinear, ModeWeights: begin
            if (nz_ff != '0) begin
               result.out_x       = q_ff[0];
               result.out_y       = q_ff[1];
               result.out_z       = q_ff[2];
               result.force_found = 1'b1;
            end
         end
         ModePriority: begin
            if (bfound_ff) begin
               result.out_x       = bvec_ff[0];
               result.out_y       = bvec_ff[1];
               result.out_z       = bvec_ff[2];
               result.force_found = 1'b1;
            end
         end
         ModeSelect: begin
            if (cfound_ff) begin
               result.out_x       = cvec_ff[0];
               result.out_y       = cvec_ff[1];
               result.out_z       = cvec_ff[2];
               result.force_found = 1'b1;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_comb begin
      cnt_in    = cnt_ff;
      wt_in     = wt_ff;
      nz_in     = nz_ff;
      bpri_in   = bpri_ff;
      bfound_in = bfound_ff;
      cfound_in = cfound_ff;
      comp_in   = comp_ff;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      neg_in    = neg_ff;
      for (int i = 0; i < 3; i++) begin
         sum_in[i]  = sum_ff[i];
         bvec_in[i] = bvec_ff[i];
         cvec_in[i] = cvec_ff[i];
         q_in[i]    = q_ff[i];
      end
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.accumulate && (cnt_ff < CountW'(MaxSources))) begin
         cnt_in = cnt_ff + 1'b1;
         if (nonzero) begin
            for (int i = 0; i < 3; i++) begin
               if (mode_ff == ModeWeights) begin
                  sum_in[i] = sum_ff[i] + SumW'(prod[i]);
               end else begin
                  sum_in[i] = sum_ff[i] + SumW'(f[i]);
               end
            end
            wt_in = wt_ff + WtW'(item_ff.source_weight);
            nz_in = nz_ff + 1'b1;
            if (!bfound_ff || (item_ff.source_priority < bpri_ff)) begin
               bfound_in = 1'b1;
               bpri_in   = item_ff.source_priority;
               for (int i = 0; i < 3; i++) begin
                  bvec_in[i] = f[i];
               end
            end
         end
         if (item_ff.source_index == sel_ff) begin
            cfound_in = 1'b1;
            for (int i = 0; i < 3; i++) begin
               cvec_in[i] = f[i];
            end
         end
      end

      if (cmd.div_load) begin
         dvd_in  = mag;
         neg_in  = cur_sum[SumW-1];
         rem_in  = '0;
         div_in  = divisor;
         step_in = '0;
      end

      if (cmd.div_step) begin
         step_in = step_ff + 1'b1;
         if (!trial[RemW]) begin
            rem_in = trial[RemW-1:0];
            dvd_in = {dvd_ff[SumW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[RemW-2:0], dvd_ff[SumW-1]};
            dvd_in = {dvd_ff[SumW-2:0], 1'b0};
         end
      end

      if (cmd.div_store) begin
         q_in[comp_ff] = sat_q;
         comp_in       = comp_ff + 1'b1;
      end

      if (cmd.finish) begin
         out_in       = result;
         rsp_valid_in = 1'b1;
         cnt_in       = '0;
         wt_in        = '0;
         nz_in        = '0;
         bpri_in      = '0;
         bfound_in    = 1'b0;
         cfound_in    = 1'b0;
         comp_in      = '0;
         for (int i = 0; i < 3; i++) begin
            sum_in[i]  = '0;
            bvec_in[i] = '0;
            cvec_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_payload;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      out_ff  <= out_in;
      for (int i = 0; i < 3; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ModeLinear;
         sel_ff       <= '0;
         cnt_ff       <= '0;
         wt_ff        <= '0;
         nz_ff        <= '0;
         bpri_ff      <= '0;
         bfound_ff    <= 1'b0;
         cfound_ff    <= 1'b0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]  <= '0;
            bvec_ff[i] <= '0;
            cvec_ff[i] <= '0;
         end
      end else begin
         mode_ff      <= mode_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         wt_ff        <= wt_in;
         nz_ff        <= nz_in;
         bpri_ff      <= bpri_in;
         bfound_ff    <= bfound_in;
         cfound_ff    <= cfound_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]  <= sum_in[i];
            bvec_ff[i] <= bvec_in[i];
            cvec_ff[i] <= cvec_in[i];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = out_ff;

   assign sts.item_last = item_ff.last_source;
   assign sts.need_div  = ((mode_ff == ModeLinear) || (mode_ff == ModeWeights)) && (nz_ff != '0);
   assign sts.step_last = (step_ff == StepW'(SumW - 1));
   assign sts.comp_last = (comp_ff == 2'd2);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import fvc_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   fvc_req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   fvc_rsp_type rsp_payload;
   logic psel;
   logic penable;
   logic pwrite;
   logic [AddrW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   force_vector_combiner_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   fvc_req_type source_words[$];
   fvc_rsp_type combined_forces[$];
   int errors = 0;
   int words_taken = 0;
   int forces_seen = 0;
   int found_seen = 0;
   int idle_cycles = 0;
   bit req_taken = 0;
   bit no_gaps = 0;
   int send_gap = 0;
   int hold_cnt = 0;
   bit hold_done = 0;

   logic [2:0] mode_q;
   logic [5:0] sel_q;
   longint acc_sum[3];
   int wt_total;
   int nz_cnt;
   int best_pri;
   bit best_ok;
   int best_v[3];
   int pick_v[3];
   bit pick_ok;
   int taken_cnt;

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic clear_particle();
      for (int i = 0; i < 3; i++) begin
         acc_sum[i] = 0;
         best_v[i] = 0;
         pick_v[i] = 0;
      end
      wt_total = 0;
      nz_cnt = 0;
      best_pri = 0;
      best_ok = 0;
      pick_ok = 0;
      taken_cnt = 0;
   endtask

   task automatic absorb_word(input fvc_req_type w);
      int f[3];
      longint q[3];
      bit ok;
      fvc_rsp_type r;
      f[0] = w.force_x;
      f[1] = w.force_y;
      f[2] = w.force_z;
      q = '{0, 0, 0};
      ok = 0;
      if (taken_cnt < MaxSources) begin
         taken_cnt++;
         if (f[0] != 0 || f[1] != 0 || f[2] != 0) begin
            for (int i = 0; i < 3; i++)
               if (mode_q == ModeWeights)
                  acc_sum[i] += longint'(f[i]) * longint'(w.source_weight);
               else
                  acc_sum[i] += longint'(f[i]);
            wt_total += int'(w.source_weight);
            nz_cnt++;
            if (!best_ok || int'(w.source_priority) < best_pri) begin
               best_ok = 1;
               best_pri = w.source_priority;
               best_v = f;
            end
         end
         if (w.source_index == sel_q) begin
            pick_ok = 1;
            pick_v = f;
         end
      end
      if (!w.last_source) return;
      case (mode_q)
         ModeLinear: begin
            if (nz_cnt > 0) begin
               ok = 1;
               for (int i = 0; i < 3; i++) q[i] = acc_sum[i] / longint'(nz_cnt);
            end
         end
         ModeWeights: begin
            if (nz_cnt > 0) begin
               ok = 1;
               for (int i = 0; i < 3; i++)
                  q[i] = (wt_total > 0) ? acc_sum[i] / longint'(wt_total) : acc_sum[i] / 256;
            end
         end
         ModePriority: begin
            if (best_ok) begin
               ok = 1;
               for (int i = 0; i < 3; i++) q[i] = best_v[i];
            end
         end
         ModeSelect: begin
            if (pick_ok) begin
               ok = 1;
               for (int i = 0; i < 3; i++) q[i] = pick_v[i];
            end
         end
         default: ok = 0;
      endcase
      r.out_x = clip32(q[0]);
      r.out_y = clip32(q[1]);
      r.out_z = clip32(q[2]);
      r.force_found = ok;
      combined_forces.push_back(r);
      clear_particle();
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
   endtask

   always @(posedge clock) begin
      fvc_rsp_type e;
      req_taken <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         words_taken++;
         absorb_word(req_payload);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         forces_seen++;
         if (rsp_payload.force_found) found_seen++;
         if (combined_forces.size() == 0) begin
            report("unexpected word", rsp_payload.out_x, 32'h0);
         end else begin
            e = combined_forces.pop_front();
            if (rsp_payload.out_x !== e.out_x) report("out_x", rsp_payload.out_x, e.out_x);
            if (rsp_payload.out_y !== e.out_y) report("out_y", rsp_payload.out_y, e.out_y);
            if (rsp_payload.out_z !== e.out_z) report("out_z", rsp_payload.out_z, e.out_z);
            if (rsp_payload.force_found !== e.force_found)
               report("force_found", 32'(rsp_payload.force_found), 32'(e.force_found));
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
         $display("tb_top failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (source_words.size() > 0) begin
            req_payload <= source_words.pop_front();
            req_valid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!hold_done && words_taken >= 300) begin
         hold_done <= 1;
         hold_cnt <= 600;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (no_gaps) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 : 1'b0;
      end
   end

   task automatic push_word(input logic [5:0] src, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [15:0] w, input logic [15:0] p,
                            input logic last);
      fvc_req_type t;
      t.source_index = src;
      t.force_x = x;
      t.force_y = y;
      t.force_z = z;
      t.source_weight = w;
      t.source_priority = p;
      t.last_source = last;
      source_words.push_back(t);
   endtask

   task automatic wait_idle();
      while (source_words.size() > 0 || req_valid || combined_forces.size() > 0 || rsp_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [AddrW-1:0] a, input logic [31:0] d);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= a;
      pwdata <= d;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic configure(input logic [2:0] m, input logic [5:0] s);
      wait_idle();
      csr_write(AddrW'(4 * RegMode), {29'd0, m});
      mode_q = m;
      csr_write(AddrW'(4 * RegSelected), {26'd0, s});
      sel_q = s;
   endtask

   function automatic logic [31:0] rand_comp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'h0;
      if (r < 20) return 32'h7fffffff;
      if (r < 25) return 32'h80000000;
      if (r < 55) return $urandom_range(0, 32'h3ffff) - 32'h20000;
      return $urandom;
   endfunction

   task automatic push_particle(input int len);
      logic [31:0] x, y, z;
      logic [15:0] w, p;
      logic [5:0] src;
      for (int i = 0; i < len; i++) begin
         src = ($urandom_range(0, 99) < 70) ? 6'(i) : 6'($urandom);
         if ($urandom_range(0, 99) < 10) begin
            x = 0;
            y = 0;
            z = 0;
         end else begin
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
         end
         case ($urandom_range(0, 9))
            0, 1: w = 16'd256;
            2: w = ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
            3, 4: w = 16'($urandom_range(0, 600) - 300);
            default: w = 16'($urandom);
         endcase
         p = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, 7) - 4) : 16'($urandom);
         push_word(src, x, y, z, w, p, i == len - 1);
      end
   endtask

   initial begin
      logic [2:0] modes[12];
      int budget;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mode_q = ModeLinear;
      sel_q = 0;
      clear_particle();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_word(0, 0, 0, 0, 256, 0, 1);
      push_word(0, 32'h7fffffff, 32'h80000000, 1, 256, 0, 0);
      push_word(1, 32'h7fffffff, 32'h80000000, 32'hffffffff, 256, 0, 1);
      configure(ModeWeights, 0);
      push_word(0, 32'h80000000, 32'h7fffffff, 5, 16'h8000, 0, 0);
      push_word(1, 32'h80000000, 32'h7fffffff, 7, 16'h8000, 0, 1);
      push_word(0, 32'h10000, 32'h20000, 0, 256, 0, 0);
      push_word(1, 32'h30000, 0, 0, 16'hff00, 0, 1);
      push_word(0, 32'h12345, 32'hfff00000, 3, 16'h7fff, 0, 1);
      wait_idle();
      configure(ModeLinear, 0);
      push_word(2, 32'h40000, 0, 0, 256, 0, 1);
      configure(ModePriority, 0);
      push_word(0, 1, 2, 3, 256, 5, 0);
      push_word(1, 4, 5, 6, 256, 5, 0);
      push_word(2, 0, 0, 0, 256, 16'h8000, 0);
      push_word(3, 7, 8, 9, 256, 16'h7fff, 1);
      push_word(0, 1, 1, 1, 256, 16'h8000, 0);
      push_word(1, 2, 2, 2, 256, 16'h8000, 1);
      configure(ModeSelect, 63);
      push_word(63, 11, 12, 13, 256, 0, 0);
      push_word(63, 14, 15, 16, 256, 0, 1);
      push_word(5, 17, 18, 19, 256, 0, 1);
      configure(3'd3, 63);
      push_word(0, 1, 2, 3, 256, 0, 1);

      modes = '{ModeLinear, ModeWeights, ModePriority, ModeSelect, 3'd3, 3'd4, 3'd6,
                3'd7, ModeWeights, ModeLinear, ModePriority, ModeSelect};
      for (int ph = 0; ph < 12; ph++) begin
         configure(modes[ph], (ph == 3) ? 6'd63 : (ph == 11) ? 6'd0 : 6'($urandom));
         no_gaps = (ph % 4 == 2);
         budget = (ph < 8) ? 70 : 60;
         if (ph == 2 || ph == 9) push_particle(70);
         while (budget > 0) begin
            if ($urandom_range(0, 99) == 0) begin
               push_particle(66);
               budget -= 66;
            end else begin
               push_particle($urandom_range(1, 8));
               budget -= 5;
            end
         end
      end
      no_gaps = 0;

      wait_idle();
      repeat (200) @(posedge clock);
      $display("covered %0d source words and %0d combined forces (%0d with a force found)",
               words_taken, forces_seen, found_seen);
      $display("modes linear, weights, priority, select and unimplemented; %0d mismatches",
               errors);
      if (errors == 0 && combined_forces.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
rtl/core/fvc_pkg.sv
rtl/core/fvc_ctrl.sv
rtl/core/fvc_datapath.sv
rtl/core/force_vector_combiner_top.sv
tb/tb_top.sv
